// ===== design/sl_pkg.sv =====
// ============================================================================
// sl_pkg - shared types, codes and helpers for the script lexer
// Token codes, scan modes, character classes and token builders.
// ============================================================================
package sl_pkg;

    localparam int OFFSET_BITS = 32;
    localparam int LINE_BITS   = 24;

    localparam int TYPE_W = 6;
    localparam int ERR_W  = 2;
    localparam int OFS_W  = 32;
    localparam int LEN_W  = 32;
    localparam int LN_W   = 24;

    localparam int BURST_MAX  = 3;
    localparam int FIFO_DEPTH = 8;
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
    localparam int FIFO_CW    = $clog2(FIFO_DEPTH + 1);

    typedef logic [OFFSET_BITS-1:0] pos_t;
    typedef logic [LINE_BITS-1:0]   line_t;
    typedef logic [TYPE_W-1:0]      ttype_t;
    typedef logic [ERR_W-1:0]       err_t;

    localparam logic KIND_CHAR = 1'b0;
    localparam logic KIND_END  = 1'b1;

    localparam ttype_t T_LPAREN    = 6'd0;
    localparam ttype_t T_RPAREN    = 6'd1;
    localparam ttype_t T_LBRACE    = 6'd2;
    localparam ttype_t T_RBRACE    = 6'd3;
    localparam ttype_t T_COMMA     = 6'd4;
    localparam ttype_t T_DOT       = 6'd5;
    localparam ttype_t T_MINUS     = 6'd6;
    localparam ttype_t T_PLUS      = 6'd7;
    localparam ttype_t T_SEMI      = 6'd8;
    localparam ttype_t T_SLASH     = 6'd9;
    localparam ttype_t T_STAR      = 6'd10;
    localparam ttype_t T_BANG      = 6'd11;
    localparam ttype_t T_BANG_EQ   = 6'd12;
    localparam ttype_t T_EQUAL     = 6'd13;
    localparam ttype_t T_EQUAL_EQ  = 6'd14;
    localparam ttype_t T_GREATER   = 6'd15;
    localparam ttype_t T_GREATER_EQ = 6'd16;
    localparam ttype_t T_LESS      = 6'd17;
    localparam ttype_t T_LESS_EQ   = 6'd18;
    localparam ttype_t T_IDENT     = 6'd19;
    localparam ttype_t T_STRING    = 6'd20;
    localparam ttype_t T_NUMBER    = 6'd21;
    localparam ttype_t T_AND       = 6'd22;
    localparam ttype_t T_CLASS     = 6'd23;
    localparam ttype_t T_ELSE      = 6'd24;
    localparam ttype_t T_FALSE     = 6'd25;
    localparam ttype_t T_FOR       = 6'd26;
    localparam ttype_t T_FN        = 6'd27;
    localparam ttype_t T_IF        = 6'd28;
    localparam ttype_t T_NIL       = 6'd29;
    localparam ttype_t T_OR        = 6'd30;
    localparam ttype_t T_PRINT     = 6'd31;
    localparam ttype_t T_RETURN    = 6'd32;
    localparam ttype_t T_SUPER     = 6'd33;
    localparam ttype_t T_THIS      = 6'd34;
    localparam ttype_t T_TRUE      = 6'd35;
    localparam ttype_t T_VAR       = 6'd36;
    localparam ttype_t T_WHILE     = 6'd37;
    localparam ttype_t T_ERROR     = 6'd38;
    localparam ttype_t T_EOF       = 6'd39;

    localparam err_t E_NONE       = 2'd0;
    localparam err_t E_UNTERM     = 2'd1;
    localparam err_t E_UNEXPECTED = 2'd2;

    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_QUOTE = 8'h22;
    localparam logic [7:0] CH_NUL   = 8'h00;

    typedef enum logic [2:0] {
        M_IDLE,
        M_WORD,
        M_INT,
        M_DOT,
        M_FRAC,
        M_STR,
        M_COMMENT,
        M_OP
    } mode_t;

    typedef enum logic [2:0] {
        OP_NONE,
        OP_BANG,
        OP_EQUAL,
        OP_LESS,
        OP_GREATER,
        OP_SLASH
    } op_t;

    typedef struct packed {
        logic              last;
        logic [LN_W-1:0]   line_number;
        logic [LEN_W-1:0]  token_length;
        logic [OFS_W-1:0]  start_offset;
        err_t              error_kind;
        ttype_t            token_type;
    } tok_t;

    typedef struct packed {
        tok_t [BURST_MAX-1:0] tokens;
        logic [1:0]           count;
    } burst_t;

    function automatic logic is_alpha(input logic [7:0] c);
        return (c inside {["a":"z"], ["A":"Z"], "_"});
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return (c inside {["0":"9"]});
    endfunction

    function automatic tok_t make_tok(input ttype_t ttype, input err_t err,
                                      input pos_t start, input pos_t stop,
                                      input line_t line);
        tok_t        t;
        pos_t        len;
        logic [63:0] len64;
        logic [63:0] start64;
        logic [31:0] line32;
        len     = stop - start;
        len64   = 64'(len);
        start64 = 64'(start);
        line32  = 32'(line);
        t.last         = 1'b0;
        t.token_type   = ttype;
        t.error_kind   = err;
        t.start_offset = start64[OFS_W-1:0];
        t.token_length = (len64 > 64'(32'hFFFF_FFFF)) ? '1 : len64[LEN_W-1:0];
        t.line_number  = (line32 > 32'(24'hFF_FFFF)) ? '1 : line32[LN_W-1:0];
        return t;
    endfunction

    function automatic ttype_t keyword_type(input logic [5:0][7:0] prefix,
                                            input logic too_long, input pos_t len);
        logic [47:0] w6;
        logic [39:0] w5;
        logic [31:0] w4;
        logic [23:0] w3;
        logic [15:0] w2;
        ttype_t      r;
        w6 = {prefix[0], prefix[1], prefix[2], prefix[3], prefix[4], prefix[5]};
        w5 = w6[47:8];
        w4 = w6[47:16];
        w3 = w6[47:24];
        w2 = w6[47:32];
        r  = T_IDENT;
        if (!too_long && len <= pos_t'(6))
        begin
            case (len[2:0])
                3'd2:
                begin
                    if (w2 == "fn") r = T_FN;
                    else if (w2 == "if") r = T_IF;
                    else if (w2 == "or") r = T_OR;
                end
                3'd3:
                begin
                    if (w3 == "and") r = T_AND;
                    else if (w3 == "for") r = T_FOR;
                    else if (w3 == "nil") r = T_NIL;
                    else if (w3 == "var") r = T_VAR;
                end
                3'd4:
                begin
                    if (w4 == "else") r = T_ELSE;
                    else if (w4 == "this") r = T_THIS;
                    else if (w4 == "true") r = T_TRUE;
                end
                3'd5:
                begin
                    if (w5 == "class") r = T_CLASS;
                    else if (w5 == "false") r = T_FALSE;
                    else if (w5 == "print") r = T_PRINT;
                    else if (w5 == "super") r = T_SUPER;
                    else if (w5 == "while") r = T_WHILE;
                end
                3'd6:
                begin
                    if (w6 == "return") r = T_RETURN;
                end
                default: r = T_IDENT;
            endcase
        end
        return r;
    endfunction

endpackage

// ===== design/sl_core.sv =====
// ============================================================================
// sl_core - scanner state and per-byte token decode
// Holds scan state; for each accepted byte produces a burst of 0..3 tokens.
// ============================================================================
module sl_core
    import sl_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       accept,
    input  logic       kind,
    input  logic [7:0] char_byte,
    output burst_t     burst
);

    mode_t            mode_reg, mode_next;
    op_t              op_reg, op_next;
    pos_t             position_reg, position_next;
    pos_t             begin_reg, begin_next;
    line_t            line_reg, line_next;
    logic [5:0][7:0]  prefix_reg, prefix_next;
    logic             too_long_reg, too_long_next;

    logic  end_item;
    pos_t  pos1;
    pos_t  dotpos;
    pos_t  word_len;
    logic  alnum;
    logic  digit;
    logic  use_flush;
    logic  use_unterm;
    logic  idle_go;
    logic  tail_eof;
    logic  tail_string;
    logic  tail_double;
    logic  op_single;

    always_comb
    begin
        end_item   = (kind == KIND_END) || (char_byte == CH_NUL);
        pos1       = position_reg + pos_t'(1);
        dotpos     = position_reg - pos_t'(1);
        word_len   = position_reg - begin_reg;
        alnum      = is_alpha(char_byte) || is_digit(char_byte);
        digit      = is_digit(char_byte);
        op_single  = (op_reg inside {OP_BANG, OP_EQUAL, OP_LESS, OP_GREATER});
        use_flush   = 1'b0;
        use_unterm  = 1'b0;
        idle_go     = 1'b0;
        tail_eof    = 1'b0;
        tail_string = 1'b0;
        tail_double = 1'b0;
        if (end_item)
        begin
            use_unterm = (mode_reg == M_STR);
            use_flush  = (mode_reg != M_STR);
            tail_eof   = 1'b1;
        end
        else
        begin
            case (mode_reg)
                M_WORD:
                begin
                    use_flush = !alnum;
                    idle_go   = !alnum;
                end
                M_INT:
                begin
                    use_flush = !digit && (char_byte != ".");
                    idle_go   = !digit && (char_byte != ".");
                end
                M_DOT, M_FRAC:
                begin
                    use_flush = !digit;
                    idle_go   = !digit;
                end
                M_STR:     tail_string = (char_byte == CH_QUOTE);
                M_COMMENT: idle_go = (char_byte == CH_LF);
                M_OP:
                begin
                    if (op_reg == OP_SLASH && char_byte == "/")
                    begin
                        use_flush = 1'b0;
                    end
                    else if (op_single && char_byte == "=")
                    begin
                        tail_double = 1'b1;
                    end
                    else
                    begin
                        use_flush = 1'b1;
                        idle_go   = 1'b1;
                    end
                end
                default:   idle_go = 1'b1;
            endcase
        end
    end

    // next state
    always_comb
    begin
        mode_next     = mode_reg;
        op_next       = op_reg;
        position_next = position_reg;
        begin_next    = begin_reg;
        line_next     = line_reg;
        prefix_next   = prefix_reg;
        too_long_next = too_long_reg;
        if (end_item)
        begin
            mode_next     = M_IDLE;
            op_next       = OP_NONE;
            position_next = '0;
            begin_next    = '0;
            line_next     = line_t'(1);
            too_long_next = 1'b0;
        end
        else
        begin
            position_next = pos1;
            if (use_flush)
            begin
                mode_next = M_IDLE;
                op_next   = OP_NONE;
            end
            case (mode_reg)
                M_WORD:
                begin
                    if (alnum)
                    begin
                        if (word_len < pos_t'(6)) prefix_next[word_len[2:0]] = char_byte;
                        else too_long_next = 1'b1;
                    end
                end
                M_INT:
                begin
                    if (char_byte == ".") mode_next = M_DOT;
                end
                M_DOT:
                begin
                    if (digit) mode_next = M_FRAC;
                end
                M_STR:
                begin
                    if (char_byte == CH_QUOTE) mode_next = M_IDLE;
                    else if (char_byte == CH_LF && line_reg != '1)
                        line_next = line_reg + line_t'(1);
                end
                M_OP:
                begin
                    if ((op_reg == OP_SLASH && char_byte == "/") || tail_double)
                    begin
                        mode_next = (tail_double) ? M_IDLE : M_COMMENT;
                        op_next   = OP_NONE;
                    end
                end
                default: ;
            endcase
            if (idle_go)
            begin
                begin_next = position_reg;
                mode_next  = M_IDLE;
                op_next    = OP_NONE;
                if (char_byte == CH_LF)
                begin
                    if (line_reg != '1) line_next = line_reg + line_t'(1);
                end
                else if (is_alpha(char_byte))
                begin
                    mode_next      = M_WORD;
                    prefix_next[0] = char_byte;
                    too_long_next  = 1'b0;
                end
                else if (digit)
                begin
                    mode_next = M_INT;
                end
                else
                begin
                    case (char_byte)
                        "!":      begin mode_next = M_OP; op_next = OP_BANG;    end
                        "=":      begin mode_next = M_OP; op_next = OP_EQUAL;   end
                        "<":      begin mode_next = M_OP; op_next = OP_LESS;    end
                        ">":      begin mode_next = M_OP; op_next = OP_GREATER; end
                        "/":      begin mode_next = M_OP; op_next = OP_SLASH;   end
                        CH_QUOTE: mode_next = M_STR;
                        default:  ;
                    endcase
                end
            end
        end
    end

    // token outputs
    tok_t       f0, f1, p0, p1, tl;
    logic [1:0] fc, pc;
    logic       tv;
    logic       idle_emit;
    ttype_t     idle_type;
    ttype_t     single_type, double_type;
    line_t      ln;

    always_comb
    begin
        ln = line_reg;
        case (op_reg)
            OP_BANG:    begin single_type = T_BANG;    double_type = T_BANG_EQ;    end
            OP_EQUAL:   begin single_type = T_EQUAL;   double_type = T_EQUAL_EQ;   end
            OP_LESS:    begin single_type = T_LESS;    double_type = T_LESS_EQ;    end
            OP_GREATER: begin single_type = T_GREATER; double_type = T_GREATER_EQ; end
            OP_SLASH:   begin single_type = T_SLASH;   double_type = T_SLASH;      end
            default:    begin single_type = T_SLASH;   double_type = T_SLASH;      end
        endcase

        f0 = make_tok(T_NUMBER, E_NONE, begin_reg, position_reg, ln);
        f1 = make_tok(T_DOT, E_NONE, dotpos, position_reg, ln);
        fc = 2'd0;
        case (mode_reg)
            M_WORD:
            begin
                f0 = make_tok(keyword_type(prefix_reg, too_long_reg, word_len), E_NONE,
                              begin_reg, position_reg, ln);
                fc = 2'd1;
            end
            M_INT, M_FRAC: fc = 2'd1;
            M_DOT:
            begin
                f0 = make_tok(T_NUMBER, E_NONE, begin_reg, dotpos, ln);
                fc = 2'd2;
            end
            M_OP:
            begin
                f0 = make_tok(single_type, E_NONE, begin_reg, position_reg, ln);
                fc = (op_reg != OP_NONE) ? 2'd1 : 2'd0;
            end
            default: fc = 2'd0;
        endcase

        p0 = f0;
        p1 = f1;
        pc = 2'd0;
        if (use_unterm)
        begin
            p0 = make_tok(T_ERROR, E_UNTERM, begin_reg, position_reg, ln);
            pc = 2'd1;
        end
        else if (use_flush)
        begin
            pc = fc;
        end

        idle_emit = 1'b1;
        case (char_byte)
            "(":     idle_type = T_LPAREN;
            ")":     idle_type = T_RPAREN;
            "{":     idle_type = T_LBRACE;
            "}":     idle_type = T_RBRACE;
            ",":     idle_type = T_COMMA;
            ".":     idle_type = T_DOT;
            "-":     idle_type = T_MINUS;
            "+":     idle_type = T_PLUS;
            ";":     idle_type = T_SEMI;
            "*":     idle_type = T_STAR;
            default:
            begin
                idle_type = T_ERROR;
                idle_emit = !(char_byte inside {CH_SPACE, CH_CR, CH_TAB, CH_LF, CH_QUOTE,
                                                "!", "=", "<", ">", "/"})
                            && !alnum;
            end
        endcase

        tv = 1'b1;
        tl = make_tok(T_EOF, E_NONE, position_reg, position_reg, ln);
        if (tail_string)
            tl = make_tok(T_STRING, E_NONE, begin_reg, pos1, ln);
        else if (tail_double)
            tl = make_tok(double_type, E_NONE, begin_reg, pos1, ln);
        else if (idle_go && idle_emit)
            tl = make_tok(idle_type, (idle_type == T_ERROR) ? E_UNEXPECTED : E_NONE,
                          position_reg, pos1, ln);
        else if (!tail_eof)
            tv = 1'b0;

        burst.tokens[0] = (pc != 2'd0) ? p0 : tl;
        burst.tokens[1] = (pc == 2'd2) ? p1 : tl;
        burst.tokens[2] = tl;
        burst.count     = pc + 2'(tv);
        burst.tokens[0].last = (burst.count == 2'd1);
        burst.tokens[1].last = (burst.count == 2'd2);
        burst.tokens[2].last = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg     <= M_IDLE;
            op_reg       <= OP_NONE;
            position_reg <= '0;
            begin_reg    <= '0;
            line_reg     <= line_t'(1);
            too_long_reg <= 1'b0;
        end
        else if (accept)
        begin
            mode_reg     <= mode_next;
            op_reg       <= op_next;
            position_reg <= position_next;
            begin_reg    <= begin_next;
            line_reg     <= line_next;
            too_long_reg <= too_long_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept) prefix_reg <= prefix_next;
    end

endmodule

// ===== design/script_lexer.sv =====
// ============================================================================
// script_lexer - single-pass lexical scanner
// Source bytes in, tokens out, one byte per cycle while the output queue has room.
// ============================================================================
// Usage:
//   Slave stream: one source byte per transaction in s_axis_tdata, with
//   s_axis_tuser = 1 marking end of source (a zero byte also ends source).
//   Master stream: one token per transaction; s_axis_tlast-style flag
//   m_axis_tlast marks the last token caused by one input byte.
//   Each accepted byte is decoded in the cycle it is taken and yields 0..3
//   tokens, written into an 8-entry output queue. The tokens of a byte are
//   registered in the queue and reach the master side behind any earlier ones.
//   Throughput: one byte per cycle while the queue holds 5 or fewer tokens;
//   a byte that yields 2 or 3 tokens only releases tokens held back by the
//   bytes before it, so with the output at full rate the queue never holds
//   more than 3 tokens and the input never stalls.
//   The queue's output port drains one token per cycle while m_axis_tready is high.
//   When the receiver stalls, tokens wait in the queue and s_axis_tready
//   drops once fewer than 3 entries are free.
//   End of source flushes any pending token, emits EOF and returns the
//   scanner to its reset state (offset 0, line 1).
//   Reset clears the scanner state and empties the queue.
// ============================================================================
module script_lexer
    import sl_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] char_byte
    input  logic        s_axis_tuser,   // [0] kind
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [95:0] m_axis_tdata,   // [5:0] token_type, [7:6] error_kind,
                                        // [39:8] start_offset, [71:40] token_length,
                                        // [95:72] line_number
    output logic        m_axis_tlast    // last
);

    burst_t             burst;
    logic               accept;
    logic               pop;
    tok_t               queue_reg [FIFO_DEPTH];
    logic [FIFO_AW-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [FIFO_CW-1:0] count_reg, count_next;
    logic [FIFO_CW-1:0] push_n;
    tok_t               head;

    sl_core u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .kind      (s_axis_tuser),
        .char_byte (s_axis_tdata),
        .burst     (burst)
    );

    always_comb
    begin
        s_axis_tready = (count_reg <= FIFO_CW'(FIFO_DEPTH - BURST_MAX));
        accept        = s_axis_tvalid && s_axis_tready;
        m_axis_tvalid = (count_reg != '0);
        pop           = m_axis_tvalid && m_axis_tready;
        push_n        = accept ? FIFO_CW'(burst.count) : '0;
        count_next    = count_reg + push_n - FIFO_CW'(pop);
        head          = queue_reg[rd_ptr_reg];
        m_axis_tdata  = {head.line_number, head.token_length, head.start_offset,
                         head.error_kind, head.token_type};
        m_axis_tlast  = head.last;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_reg + FIFO_AW'(push_n);
            rd_ptr_reg <= rd_ptr_reg + FIFO_AW'(pop);
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < BURST_MAX; i++)
        begin
            if (accept && (2'(i) < burst.count))
                queue_reg[wr_ptr_reg + FIFO_AW'(i)] <= burst.tokens[i];
        end
    end

endmodule

// ===== design/sl_checker.sv =====
// ============================================================================
// sl_checker - port-level checks for the script lexer
// Watches both streams for stable stalled transfers and the master stream for consistent token records.
// ============================================================================
module sl_checker
    import sl_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    input  logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,
    input  logic        s_axis_tuser,
    input  logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    input  logic [95:0] m_axis_tdata,
    input  logic        m_axis_tlast
);

    a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && !s_axis_tready
        |=> s_axis_tvalid && $stable(s_axis_tdata) && $stable(s_axis_tuser))
        else $error("source byte changed while stalled");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("token changed while stalled");

    a_err_type: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tdata[7:6] != E_NONE |-> m_axis_tdata[5:0] == T_ERROR)
        else $error("error kind on a non-error token");

    a_eof_shape: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tdata[5:0] == T_EOF
        |-> m_axis_tlast && m_axis_tdata[71:40] == '0 && m_axis_tdata[7:6] == E_NONE)
        else $error("malformed eof token");

    a_line_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> m_axis_tdata[95:72] != '0)
        else $error("line number zero");

endmodule

bind script_lexer sl_checker u_sl_checker (.*);
